// ----- hw/rtl/fcb_pkg.sv -----
package fcb_pkg;

  localparam int GLYPH_COUNT = 95;
  localparam int GLYPH_BITS  = 35;
  localparam int IDX_W       = 7;
  localparam int POS_W       = 19;

  typedef enum logic [1:0] {
    REQ_DRAW   = 2'd0,
    REQ_DEFINE = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NONE   = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    CFG_SCALE  = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_BAR,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [7:0]         char_code;
    logic [6:0]         glyph_col0;
    logic [6:0]         glyph_col1;
    logic [6:0]         glyph_col2;
    logic [6:0]         glyph_col3;
    logic [6:0]         glyph_col4;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic               first_in_string;
    logic [15:0]        color;
  } req_t;

  typedef struct packed {
    logic [11:0] rect_x0;
    logic [11:0] rect_y0;
    logic [12:0] rect_x1;
    logic [12:0] rect_y1;
    logic [15:0] fill_color;
    logic        last_rect;
  } rect_t;

  // Column 0 lands in the low bits, so dot (c, r) is bit 7*c + r.
  function automatic logic [GLYPH_BITS-1:0] pk(input logic [6:0] c0, input logic [6:0] c1,
                                               input logic [6:0] c2, input logic [6:0] c3,
                                               input logic [6:0] c4);
    pk = {c4, c3, c2, c1, c0};
  endfunction

  // Built-in font for codes 32..126, addressed by code minus 32.
  function automatic logic [GLYPH_BITS-1:0] rom_glyph(input logic [IDX_W-1:0] idx);
    logic [GLYPH_BITS-1:0] g;
    case (idx)
      7'd0:  g = pk(7'h00, 7'h00, 7'h00, 7'h00, 7'h00);
      7'd1:  g = pk(7'h00, 7'h00, 7'h5f, 7'h00, 7'h00);
      7'd2:  g = pk(7'h00, 7'h07, 7'h00, 7'h07, 7'h00);
      7'd3:  g = pk(7'h14, 7'h7f, 7'h14, 7'h7f, 7'h14);
      7'd4:  g = pk(7'h24, 7'h2a, 7'h7f, 7'h2a, 7'h12);
      7'd5:  g = pk(7'h23, 7'h13, 7'h08, 7'h64, 7'h62);
      7'd6:  g = pk(7'h36, 7'h49, 7'h55, 7'h22, 7'h50);
      7'd7:  g = pk(7'h00, 7'h05, 7'h03, 7'h00, 7'h00);
      7'd8:  g = pk(7'h00, 7'h1c, 7'h22, 7'h41, 7'h00);
      7'd9:  g = pk(7'h00, 7'h41, 7'h22, 7'h1c, 7'h00);
      7'd10: g = pk(7'h14, 7'h08, 7'h3e, 7'h08, 7'h14);
      7'd11: g = pk(7'h08, 7'h08, 7'h3e, 7'h08, 7'h08);
      7'd12: g = pk(7'h00, 7'h50, 7'h30, 7'h00, 7'h00);
      7'd13: g = pk(7'h08, 7'h08, 7'h08, 7'h08, 7'h08);
      7'd14: g = pk(7'h00, 7'h60, 7'h60, 7'h00, 7'h00);
      7'd15: g = pk(7'h20, 7'h10, 7'h08, 7'h04, 7'h02);
      7'd16: g = pk(7'h3e, 7'h51, 7'h49, 7'h45, 7'h3e);
      7'd17: g = pk(7'h00, 7'h42, 7'h7f, 7'h40, 7'h00);
      7'd18: g = pk(7'h42, 7'h61, 7'h51, 7'h49, 7'h46);
      7'd19: g = pk(7'h21, 7'h41, 7'h45, 7'h4b, 7'h31);
      7'd20: g = pk(7'h18, 7'h14, 7'h12, 7'h7f, 7'h10);
      7'd21: g = pk(7'h27, 7'h45, 7'h45, 7'h45, 7'h39);
      7'd22: g = pk(7'h3c, 7'h4a, 7'h49, 7'h49, 7'h30);
      7'd23: g = pk(7'h01, 7'h71, 7'h09, 7'h05, 7'h03);
      7'd24: g = pk(7'h36, 7'h49, 7'h49, 7'h49, 7'h36);
      7'd25: g = pk(7'h06, 7'h49, 7'h49, 7'h29, 7'h1e);
      7'd26: g = pk(7'h00, 7'h36, 7'h36, 7'h00, 7'h00);
      7'd27: g = pk(7'h00, 7'h56, 7'h36, 7'h00, 7'h00);
      7'd28: g = pk(7'h08, 7'h14, 7'h22, 7'h41, 7'h00);
      7'd29: g = pk(7'h14, 7'h14, 7'h14, 7'h14, 7'h14);
      7'd30: g = pk(7'h00, 7'h41, 7'h22, 7'h14, 7'h08);
      7'd31: g = pk(7'h02, 7'h01, 7'h51, 7'h09, 7'h06);
      7'd32: g = pk(7'h32, 7'h49, 7'h79, 7'h41, 7'h3e);
      7'd33: g = pk(7'h7e, 7'h11, 7'h11, 7'h11, 7'h7e);
      7'd34: g = pk(7'h7f, 7'h49, 7'h49, 7'h49, 7'h36);
      7'd35: g = pk(7'h3e, 7'h41, 7'h41, 7'h41, 7'h22);
      7'd36: g = pk(7'h7f, 7'h41, 7'h41, 7'h22, 7'h1c);
      7'd37: g = pk(7'h7f, 7'h49, 7'h49, 7'h49, 7'h41);
      7'd38: g = pk(7'h7f, 7'h09, 7'h09, 7'h09, 7'h01);
      7'd39: g = pk(7'h3e, 7'h41, 7'h49, 7'h49, 7'h7a);
      7'd40: g = pk(7'h7f, 7'h08, 7'h08, 7'h08, 7'h7f);
      7'd41: g = pk(7'h00, 7'h41, 7'h7f, 7'h41, 7'h00);
      7'd42: g = pk(7'h20, 7'h40, 7'h41, 7'h3f, 7'h01);
      7'd43: g = pk(7'h7f, 7'h08, 7'h14, 7'h22, 7'h41);
      7'd44: g = pk(7'h7f, 7'h40, 7'h40, 7'h40, 7'h40);
      7'd45: g = pk(7'h7f, 7'h02, 7'h0c, 7'h02, 7'h7f);
      7'd46: g = pk(7'h7f, 7'h04, 7'h08, 7'h10, 7'h7f);
      7'd47: g = pk(7'h3e, 7'h41, 7'h41, 7'h41, 7'h3e);
      7'd48: g = pk(7'h7f, 7'h09, 7'h09, 7'h09, 7'h06);
      7'd49: g = pk(7'h3e, 7'h41, 7'h51, 7'h21, 7'h5e);
      7'd50: g = pk(7'h7f, 7'h09, 7'h19, 7'h29, 7'h46);
      7'd51: g = pk(7'h46, 7'h49, 7'h49, 7'h49, 7'h31);
      7'd52: g = pk(7'h01, 7'h01, 7'h7f, 7'h01, 7'h01);
      7'd53: g = pk(7'h3f, 7'h40, 7'h40, 7'h40, 7'h3f);
      7'd54: g = pk(7'h1f, 7'h20, 7'h40, 7'h20, 7'h1f);
      7'd55: g = pk(7'h3f, 7'h40, 7'h38, 7'h40, 7'h3f);
      7'd56: g = pk(7'h63, 7'h14, 7'h08, 7'h14, 7'h63);
      7'd57: g = pk(7'h07, 7'h08, 7'h70, 7'h08, 7'h07);
      7'd58: g = pk(7'h61, 7'h51, 7'h49, 7'h45, 7'h43);
      7'd59: g = pk(7'h00, 7'h7f, 7'h41, 7'h41, 7'h00);
      7'd60: g = pk(7'h02, 7'h04, 7'h08, 7'h10, 7'h20);
      7'd61: g = pk(7'h00, 7'h41, 7'h41, 7'h7f, 7'h00);
      7'd62: g = pk(7'h04, 7'h02, 7'h01, 7'h02, 7'h04);
      7'd63: g = pk(7'h40, 7'h40, 7'h40, 7'h40, 7'h40);
      7'd64: g = pk(7'h00, 7'h01, 7'h02, 7'h04, 7'h00);
      7'd65: g = pk(7'h20, 7'h54, 7'h54, 7'h54, 7'h78);
      7'd66: g = pk(7'h7f, 7'h48, 7'h44, 7'h44, 7'h38);
      7'd67: g = pk(7'h38, 7'h44, 7'h44, 7'h44, 7'h20);
      7'd68: g = pk(7'h38, 7'h44, 7'h44, 7'h48, 7'h7f);
      7'd69: g = pk(7'h38, 7'h54, 7'h54, 7'h54, 7'h18);
      7'd70: g = pk(7'h08, 7'h7e, 7'h09, 7'h01, 7'h02);
      7'd71: g = pk(7'h0c, 7'h52, 7'h52, 7'h52, 7'h3e);
      7'd72: g = pk(7'h7f, 7'h08, 7'h04, 7'h04, 7'h78);
      7'd73: g = pk(7'h00, 7'h44, 7'h7d, 7'h40, 7'h00);
      7'd74: g = pk(7'h20, 7'h40, 7'h44, 7'h3d, 7'h00);
      7'd75: g = pk(7'h7f, 7'h10, 7'h28, 7'h44, 7'h00);
      7'd76: g = pk(7'h00, 7'h41, 7'h7f, 7'h40, 7'h00);
      7'd77: g = pk(7'h7c, 7'h04, 7'h18, 7'h04, 7'h78);
      7'd78: g = pk(7'h7c, 7'h08, 7'h04, 7'h04, 7'h78);
      7'd79: g = pk(7'h38, 7'h44, 7'h44, 7'h44, 7'h38);
      7'd80: g = pk(7'h7c, 7'h14, 7'h14, 7'h14, 7'h08);
      7'd81: g = pk(7'h08, 7'h14, 7'h14, 7'h18, 7'h7c);
      7'd82: g = pk(7'h7c, 7'h08, 7'h04, 7'h04, 7'h08);
      7'd83: g = pk(7'h48, 7'h54, 7'h54, 7'h54, 7'h20);
      7'd84: g = pk(7'h04, 7'h3f, 7'h44, 7'h40, 7'h20);
      7'd85: g = pk(7'h3c, 7'h40, 7'h40, 7'h20, 7'h7c);
      7'd86: g = pk(7'h1c, 7'h20, 7'h40, 7'h20, 7'h1c);
      7'd87: g = pk(7'h3c, 7'h40, 7'h30, 7'h40, 7'h3c);
      7'd88: g = pk(7'h44, 7'h28, 7'h10, 7'h28, 7'h44);
      7'd89: g = pk(7'h0c, 7'h50, 7'h50, 7'h50, 7'h3c);
      7'd90: g = pk(7'h44, 7'h64, 7'h54, 7'h4c, 7'h44);
      7'd91: g = pk(7'h00, 7'h08, 7'h36, 7'h41, 7'h00);
      7'd92: g = pk(7'h00, 7'h00, 7'h7f, 7'h00, 7'h00);
      7'd93: g = pk(7'h00, 7'h41, 7'h36, 7'h08, 7'h00);
      7'd94: g = pk(7'h08, 7'h04, 7'h08, 7'h10, 7'h08);
      default: g = '0;
    endcase
    rom_glyph = g;
  endfunction

endpackage

// ----- hw/rtl/fcb_ram.sv -----
module fcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/bitmap_font_char_blitter.sv -----
// Channel  | Handshake             | Beat
// request  | start, busy           | req (req_t), accepted when start and not busy
// config   | cfg_valid, cfg_ready  | cfg_index, cfg_data
// result   | rect_valid (strobe)   | rect (rect_t), one cycle each
//
// A glyph draw holds busy through the look state (glyph store read), the scan state, which
// shifts out the 35 dots of the glyph register, and the flush state for the held rectangle.
// A bar draw holds it through the look, bar and flush states. A new request waits for idle.
// Define, clear, space, scale-zero and unknown requests finish at the accepting edge.
// Register writes are taken only while busy is low.
// Reset clears the pen, the glyph valid bits and the registers to their defaults.
// Results go out as strobes; the receiver cannot stall them.
module bitmap_font_char_blitter
  import fcb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        req,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  output logic        rect_valid,
  output rect_t       rect
);

  state_t state, state_next;

  logic [3:0]  scale;
  logic [12:0] surface_width;
  logic [12:0] surface_height;

  logic signed [15:0] pen_x, pen_y;
  logic [GLYPH_COUNT-1:0] glyph_valid;

  logic [IDX_W-1:0] idx;
  logic             in_range;
  logic             accept;
  logic             custom_hit;
  logic [GLYPH_BITS-1:0] ram_rdata;

  logic [7:0]  code;
  logic [15:0] color;
  logic [3:0]  s;
  logic signed [POS_W-1:0] bx, by, cx, cy;
  logic [GLYPH_BITS-1:0] shreg;
  logic [2:0]  row;
  logic [5:0]  cnt;

  rect_t pend;
  logic  pend_valid;

  assign cfg_ready = !busy;
  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign idx       = IDX_W'(req.char_code - 8'd32);
  assign in_range  = (req.char_code >= 8'd32) && (req.char_code <= 8'd126)
                     && (idx < IDX_W'(GLYPH_COUNT));

  // Custom glyph store.
  fcb_ram #(.WIDTH(GLYPH_BITS), .DEPTH(GLYPH_COUNT)) u_ram (
    .clk   (clk),
    .we    (accept && req.req_type == REQ_DEFINE && in_range),
    .waddr (idx),
    .wdata ({req.glyph_col4, req.glyph_col3, req.glyph_col2, req.glyph_col1,
             req.glyph_col0}),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      scale          <= 4'd1;
      surface_width  <= 13'd320;
      surface_height <= 13'd240;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_SCALE:  scale          <= cfg_data[3:0];
        CFG_WIDTH:  surface_width  <= cfg_data;
        CFG_HEIGHT: surface_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pen after an optional load, and after the advance.
  logic signed [15:0]      pen_lx, pen_ly;
  logic signed [POS_W-1:0] adv;
  logic [6:0]              six_s;
  assign pen_lx = req.first_in_string ? req.start_x : pen_x;
  assign pen_ly = req.first_in_string ? req.start_y : pen_y;
  assign six_s  = {1'b0, scale, 2'b00} + {2'b00, scale, 1'b0};
  assign adv    = POS_W'(pen_lx) + POS_W'($signed({1'b0, six_s}));

  // Rectangle evaluation, shared by the dot scan and the bar.
  logic signed [POS_W-1:0] ex, ey, ew, eh, ex1, ey1, cx0, cy0, cx1, cy1;
  logic signed [POS_W-1:0] lim_w, lim_h;
  logic [6:0] s3;
  logic       hit, dot;
  assign s3    = {3'b000, s} + {2'b00, s, 1'b0};
  assign lim_w = (surface_width > 13'd4096) ? POS_W'(4096) : POS_W'({1'b0, surface_width});
  assign lim_h = (surface_height > 13'd4096) ? POS_W'(4096) : POS_W'({1'b0, surface_height});

  always_comb begin
    if (state == ST_BAR) begin
      ex = bx + POS_W'({1'b0, s});
      ey = by + POS_W'({1'b0, s, 2'b00}) + POS_W'({1'b0, s, 1'b0});
      ew = POS_W'({1'b0, s3});
      eh = POS_W'({1'b0, s});
      dot = 1'b1;
    end else begin
      ex = cx;
      ey = cy;
      ew = POS_W'({1'b0, s});
      eh = POS_W'({1'b0, s});
      dot = shreg[0];
    end
    ex1 = ex + ew;
    ey1 = ey + eh;
    cx0 = (ex < 0) ? '0 : ex;
    cy0 = (ey < 0) ? '0 : ey;
    cx1 = (ex1 > lim_w) ? lim_w : ex1;
    cy1 = (ey1 > lim_h) ? lim_h : ey1;
    hit = dot && (cx0 < cx1) && (cy0 < cy1);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept && req.req_type == REQ_DRAW && scale != 4'd0
                    && req.char_code != 8'd32) begin
        state_next = ST_LOOK;
      end
      ST_LOOK:  state_next = ((code >= 8'd32) && (code <= 8'd126)) ? ST_SCAN : ST_BAR;
      ST_SCAN:  if (cnt == 6'(GLYPH_BITS - 1)) begin
        state_next = ST_FLUSH;
      end
      ST_BAR:   state_next = ST_FLUSH;
      ST_FLUSH: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Pen and glyph valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x       <= '0;
      pen_y       <= '0;
      glyph_valid <= '0;
    end else if (accept) begin
      case (req_type_t'(req.req_type))
        REQ_DEFINE: if (in_range) begin
          glyph_valid[idx] <= 1'b1;
        end
        REQ_CLEAR: glyph_valid <= '0;
        REQ_DRAW: begin
          pen_y <= pen_ly;
          if (scale == 4'd0) begin
            pen_x <= pen_lx;
          end else if (adv > POS_W'(32767)) begin
            pen_x <= 16'sd32767;
          end else begin
            pen_x <= adv[15:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Item datapath: latch at accept, serial dot scan afterwards.
  always_ff @(posedge clk) begin
    if (accept) begin
      code       <= req.char_code;
      color      <= req.color;
      s          <= scale;
      bx         <= POS_W'(pen_lx);
      by         <= POS_W'(pen_ly);
      custom_hit <= in_range && glyph_valid[idx];
    end
    case (state)
      ST_LOOK: begin
        shreg <= custom_hit ? ram_rdata : rom_glyph(IDX_W'(code - 8'd32));
        cx    <= bx;
        cy    <= by;
        row   <= '0;
        cnt   <= '0;
      end
      ST_SCAN: begin
        shreg <= shreg >> 1;
        cnt   <= cnt + 6'd1;
        if (row == 3'd6) begin
          row <= '0;
          cy  <= by;
          cx  <= cx + POS_W'({1'b0, s});
        end else begin
          row <= row + 3'd1;
          cy  <= cy + POS_W'({1'b0, s});
        end
      end
      default: ;
    endcase
  end

  // A found rectangle is held until the next one or the flush, so the final one can carry last_rect.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      rect_valid <= 1'b0;
    end else begin
      rect_valid <= 1'b0;
      if ((state == ST_SCAN || state == ST_BAR) && hit) begin
        pend_valid <= 1'b1;
        rect_valid <= pend_valid;
      end else if (state == ST_FLUSH) begin
        pend_valid <= 1'b0;
        rect_valid <= pend_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_SCAN || state == ST_BAR) && hit) begin
      pend.rect_x0    <= cx0[11:0];
      pend.rect_y0    <= cy0[11:0];
      pend.rect_x1    <= cx1[12:0];
      pend.rect_y1    <= cy1[12:0];
      pend.fill_color <= color;
      pend.last_rect  <= 1'b0;
      rect            <= pend;
    end else if (state == ST_FLUSH) begin
      rect <= {pend[$bits(rect_t)-1:1], 1'b1};
    end
  end

  // Emitted rectangles are never empty.
  assert property (@(posedge clk) disable iff (rst)
    rect_valid |-> ({1'b0, rect.rect_x0} < rect.rect_x1)) else $error("empty x span");
  assert property (@(posedge clk) disable iff (rst)
    rect_valid |-> ({1'b0, rect.rect_y0} < rect.rect_y1)) else $error("empty y span");
  // The last rectangle of a character is never followed at once by another.
  assert property (@(posedge clk) disable iff (rst)
    rect_valid && rect.last_rect |=> !rect_valid) else $error("result after last");

endmodule
